[src/mfbt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfbt_pkg
// Shared constants and types for the most-frequent-byte tracker.
// ----------------------------------------------------------------------------
package mfbt_pkg;

    localparam int MAX_LEN = 1024;                  // count saturation point
    localparam int CHAR_W  = 8;                     // byte width
    localparam int DEPTH   = 256;                   // histogram entries
    localparam int CNT_W   = $clog2(MAX_LEN + 1);   // stored count width
    localparam int OUT_W   = 11;                    // mode_count port width

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // Histogram write-back from the update stage.
    typedef struct packed {
        logic  en;      // write count at addr
        char_t addr;
        cnt_t  cnt;
        logic  clear;   // end of string: drop all entries after this write
    } hist_upd_t;

endpackage : mfbt_pkg
`default_nettype wire

[src/most_frequent_byte_tracker_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// most_frequent_byte_tracker_core
// Byte histogram mode: streams bytes, reports the byte that first reached
// the highest occurrence count at each end-of-string transfer.
// ----------------------------------------------------------------------------
//  Channel  Dir  Ports                                  Transfer
//  s_       in   s_char_in, s_end_of_string             s_valid & s_ready
//  m_       out  m_mode_char, m_mode_count              m_valid & m_ready
//
// One byte per cycle sustained. A byte is read from the count RAM on the
// cycle it transfers and updated from the registered RAM read data; the
// last write is forwarded so back-to-back repeats of a byte count right.
// Reset clears the valid bits at once: no clearing pass, s_ready is high
// the cycle after reset. Only an end-of-string byte can stall: it waits in
// the update stage while the result register still holds an untaken result.
// ----------------------------------------------------------------------------
module most_frequent_byte_tracker_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire mfbt_pkg::char_t s_char_in,
    input  wire logic            s_end_of_string,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [7:0]           m_mode_char,
    output logic [10:0]          m_mode_count
);
    import mfbt_pkg::*;

    // Update stage (item whose count is being read back)
    logic  s1_valid_reg;
    char_t s1_char_reg;
    logic  s1_last_reg;
    logic  s1_adv;
    logic  s_xfer;

    cnt_t      cur_cnt;
    cnt_t      new_cnt;
    hist_upd_t upd;

    // Running best of the current string
    char_t best_char_reg;
    cnt_t  best_cnt_reg;
    char_t best_char_next;
    cnt_t  best_cnt_next;
    logic  best_take;

    // Result register
    logic  m_valid_reg;
    char_t m_char_reg;
    cnt_t  m_cnt_reg;

    // A last byte may move on only if the result register frees up.
    assign s1_adv  = s1_valid_reg && (!s1_last_reg || !m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_adv;
    assign s_xfer  = s_valid && s_ready;

    mfbt_hist u_hist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (s_xfer),
        .rd_addr   (s_char_in),
        .look_addr (s1_char_reg),
        .upd       (upd),
        .look_cnt  (cur_cnt)
    );

    // Saturating increment
    assign new_cnt = (cur_cnt < cnt_t'(MAX_LEN)) ? cur_cnt + cnt_t'(1) : cur_cnt;

    always_comb begin
        upd.en    = s1_adv;
        upd.addr  = s1_char_reg;
        upd.cnt   = new_cnt;
        upd.clear = s1_last_reg;
    end

    // Strictly greater: ties keep the byte that got there first.
    assign best_take      = new_cnt > best_cnt_reg;
    assign best_char_next = best_take ? s1_char_reg : best_char_reg;
    assign best_cnt_next  = best_take ? new_cnt : best_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            s1_char_reg <= s_char_in;
            s1_last_reg <= s_end_of_string;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_char_reg <= '0;
            best_cnt_reg  <= '0;
        end else if (s1_adv) begin
            if (s1_last_reg) begin
                best_char_reg <= '0;
                best_cnt_reg  <= '0;
            end else begin
                best_char_reg <= best_char_next;
                best_cnt_reg  <= best_cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv && s1_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_last_reg) begin
            m_char_reg <= best_char_next;
            m_cnt_reg  <= best_cnt_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_mode_char  = m_char_reg;
    assign m_mode_count = OUT_W'(m_cnt_reg);

endmodule : most_frequent_byte_tracker_core
`default_nettype wire

[src/mfbt_count_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfbt_count_ram
// Count storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mfbt_count_ram (
    input  wire logic           aclk,
    input  wire logic           wr_en,
    input  wire mfbt_pkg::char_t wr_addr,
    input  wire mfbt_pkg::cnt_t  wr_data,
    input  wire logic           rd_en,
    input  wire mfbt_pkg::char_t rd_addr,
    output mfbt_pkg::cnt_t       rd_data
);
    import mfbt_pkg::*;

    cnt_t mem [DEPTH];
    cnt_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read-before-write on a same-address collision; the caller forwards.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : mfbt_count_ram
`default_nettype wire

[src/mfbt_hist.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfbt_hist
// Histogram: count RAM, per-entry valid bits and write forwarding.
// ----------------------------------------------------------------------------
module mfbt_hist (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              rd_en,
    input  wire mfbt_pkg::char_t   rd_addr,
    input  wire mfbt_pkg::char_t   look_addr,   // address read last time rd_en was high
    input  wire mfbt_pkg::hist_upd_t upd,
    output mfbt_pkg::cnt_t         look_cnt
);
    import mfbt_pkg::*;

    cnt_t ram_data;

    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;

    // Last write: newer than the RAM read data when addresses collide.
    char_t fwd_addr_reg;
    cnt_t  fwd_cnt_reg;

    mfbt_count_ram u_ram (
        .aclk    (aclk),
        .wr_en   (upd.en),
        .wr_addr (upd.addr),
        .wr_data (upd.cnt),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_data)
    );

    always_comb begin
        valid_next = valid_reg;
        if (upd.en) begin
            if (upd.clear) begin
                valid_next = '0;
            end else begin
                valid_next[upd.addr] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd.en) begin
            fwd_addr_reg <= upd.addr;
            fwd_cnt_reg  <= upd.cnt;
        end
    end

    // Invalid entry reads as zero; valid bits already reflect every write.
    always_comb begin
        if (!valid_reg[look_addr]) begin
            look_cnt = '0;
        end else if (fwd_addr_reg == look_addr) begin
            look_cnt = fwd_cnt_reg;
        end else begin
            look_cnt = ram_data;
        end
    end

endmodule : mfbt_hist
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds byte strings into most_frequent_byte_tracker_core and checks every
// reported mode byte and count against a running histogram kept here (or a
// pinned row). A short table of directed strings comes first. Random strings
// with random pacing on both channels follow. One long string at the end
// drives one byte into count saturation among sparse noise bytes.
// ----------------------------------------------------------------------------
module testbench;
    import mfbt_pkg::*;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 150;
    localparam int STALL_LIMIT  = 2000;  // cycles without any transfer
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_REPORTS  = 10;

    // One reported result: the winning byte and its occurrence count.
    typedef struct packed {
        logic [7:0]  ch;
        logic [10:0] cnt;
    } mode_t;

    // One directed byte. When pinned is set, the expected result is typed in
    // the row; otherwise the histogram below supplies it.
    typedef struct packed {
        logic        pinned;
        logic [7:0]  ch;
        logic        last;
        logic [7:0]  x_ch;
        logic [10:0] x_cnt;
    } stim_row_t;

    // Content mix of a random string.
    typedef enum int {
        FEW_BYTES,   // four neighboring values: many repeats and ties
        ANY_BYTE,    // full range, mostly distinct
        ONE_HEAVY    // one dominant byte with random noise
    } mix_t;

    localparam int NUM_DIRECTED = 22;

    // Directed strings. Each string ends on a row whose last flag is set.
    stim_row_t directed [NUM_DIRECTED] = '{
        // single-byte strings at both extremes of the byte range
        '{1'b1, 8'h00, 1'b1, 8'h00, 11'd1},
        '{1'b1, 8'hFF, 1'b1, 8'hFF, 11'd1},
        // plain majority
        '{1'b0, 8'h80, 1'b0, 8'h00, 11'd0},
        '{1'b0, 8'h01, 1'b0, 8'h00, 11'd0},
        '{1'b0, 8'h80, 1'b1, 8'h00, 11'd0},
        // tie: the later-starting byte reaches two first
        '{1'b0, 8'h10, 1'b0, 8'h00, 11'd0},
        '{1'b0, 8'h20, 1'b0, 8'h00, 11'd0},
        '{1'b0, 8'h20, 1'b0, 8'h00, 11'd0},
        '{1'b0, 8'h10, 1'b1, 8'h00, 11'd0},
        // tie: the earlier byte reaches two first
        '{1'b0, 8'h30, 1'b0, 8'h00, 11'd0},
        '{1'b0, 8'h31, 1'b0, 8'h00, 11'd0},
        '{1'b0, 8'h30, 1'b0, 8'h00, 11'd0},
        '{1'b0, 8'h31, 1'b1, 8'h00, 11'd0},
        // back-to-back repeats exercise the write forwarding
        '{1'b0, 8'h55, 1'b0, 8'h00, 11'd0},
        '{1'b0, 8'h55, 1'b0, 8'h00, 11'd0},
        '{1'b0, 8'h55, 1'b1, 8'h00, 11'd0},
        // lead changes hands twice
        '{1'b0, 8'h00, 1'b0, 8'h00, 11'd0},
        '{1'b0, 8'hFF, 1'b0, 8'h00, 11'd0},
        '{1'b0, 8'hFF, 1'b0, 8'h00, 11'd0},
        '{1'b0, 8'h00, 1'b0, 8'h00, 11'd0},
        '{1'b0, 8'h00, 1'b1, 8'h00, 11'd0},
        // histogram must be empty again after the previous string
        '{1'b1, 8'hAA, 1'b1, 8'hAA, 11'd1}
    };

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    char_t       s_char_in       = '0;
    logic        s_end_of_string = 1'b0;
    logic        m_ready         = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [7:0]  m_mode_char;
    logic [10:0] m_mode_count;

    // Histogram held by the testbench, mirrors what the block should track.
    int unsigned hist_count [DEPTH];
    bit          hist_seen  [DEPTH];
    int unsigned best_byte  = 0;
    int unsigned best_tally = 0;

    mode_t pending_modes [$];   // expected results, oldest first
    int    errors       = 0;
    int    stall_cycles = 0;
    int    send_calm    = 0;    // items left in a stretch without gaps

    always #HALF_PERIOD aclk = ~aclk;

    most_frequent_byte_tracker_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_in       (s_char_in),
        .s_end_of_string (s_end_of_string),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_mode_char     (m_mode_char),
        .m_mode_count    (m_mode_count)
    );

    // Count one byte into the histogram. Returns 1 on the last byte of a
    // string, with the mode in res, and clears the string state.
    function automatic bit tally_byte(input logic [7:0] c, input logic last,
                                      output mode_t res);
        int unsigned n;
        n = hist_seen[c] ? hist_count[c] : 0;
        if (n < MAX_LEN) n++;               // saturate
        hist_count[c] = n;
        hist_seen[c]  = 1'b1;
        // strict compare: on a tie the earlier byte keeps the lead
        if (n > best_tally) begin
            best_tally = n;
            best_byte  = c;
        end
        res.ch  = best_byte[7:0];
        res.cnt = best_tally[10:0];
        if (last) begin
            foreach (hist_seen[i]) hist_seen[i] = 1'b0;
            best_byte  = 0;
            best_tally = 0;
        end
        return last;
    endfunction

    // Idle cycles before the next input transfer: mostly none or short,
    // a few long, and now and then a stretch with no gaps at all.
    function automatic int pick_gap();
        int r;
        if (send_calm > 0) begin
            send_calm--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 3) begin
            send_calm = $urandom_range(100, 20);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(30, 5);
    endfunction

    task automatic report(input string what, input mode_t want, input mode_t got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t: %s: expected char %h count %0d, got char %h count %0d",
                     $time, what, want.ch, want.cnt, got.ch, got.cnt);
    endtask

    // Drive one byte and hold it until the transfer. Payload changes only
    // at the falling edge; the transfer is seen at the rising edge.
    task automatic send_byte(input logic [7:0] c, input logic last,
                             input logic pinned, input mode_t pinned_mode);
        int    gap;
        mode_t res;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid         = 1'b1;
        s_char_in       = c;
        s_end_of_string = last;
        do @(posedge aclk); while (!s_ready);
        if (tally_byte(c, last, res))
            pending_modes.push_back(pinned ? pinned_mode : res);
    endtask

    // Output-side pacing: ready held for spans of random length, with long
    // open stretches and a few long stalls.
    initial begin : sink_pacing
        int   r;
        int   span;
        logic lvl;
        forever begin
            r = $urandom_range(99);
            if (r < 50) begin
                lvl  = 1'b1;
                span = $urandom_range(8, 1);
            end else if (r < 60) begin
                lvl  = 1'b1;
                span = $urandom_range(150, 30);
            end else if (r < 92) begin
                lvl  = 1'b0;
                span = $urandom_range(3, 1);
            end else begin
                lvl  = 1'b0;
                span = $urandom_range(40, 8);
            end
            repeat (span) begin
                @(negedge aclk);
                m_ready = lvl;
            end
        end
    end

    // Result check: every output transfer against the oldest expectation.
    always @(posedge aclk) begin : result_check
        mode_t want;
        mode_t got;
        if (aresetn && m_valid && m_ready) begin
            got.ch  = m_mode_char;
            got.cnt = m_mode_count;
            if (pending_modes.size() == 0) begin
                report("result with none pending", '0, got);
            end else begin
                want = pending_modes.pop_front();
                if (got.ch !== want.ch || got.cnt !== want.cnt)
                    report("mode mismatch", want, got);
            end
        end
    end

    // Watchdog: any transfer on either side restarts the count.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin : watchdog
        wait (stall_cycles >= STALL_LIMIT);
        $display("testbench: done, errors");
        $finish;
    end

    initial begin : stimulus
        stim_row_t   row;
        mode_t       pinned_mode;
        mix_t        mix;
        int          sent;
        int          len;
        int          r;
        int          k;
        logic [7:0]  base;
        logic [7:0]  c;
        logic [7:0]  heavy;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed table
        foreach (directed[i]) begin
            row             = directed[i];
            pinned_mode.ch  = row.x_ch;
            pinned_mode.cnt = row.x_cnt;
            send_byte(row.ch, row.last, row.pinned, pinned_mode);
        end

        // Random strings: mostly short so results come often, some long.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            r = $urandom_range(99);
            if (r < 70)
                len = $urandom_range(8, 1);
            else if (r < 95)
                len = $urandom_range(40, 9);
            else
                len = $urandom_range(200, 41);
            mix  = mix_t'($urandom_range(2));
            base = 8'($urandom_range(255));
            for (k = 0; k < len; k++) begin
                case (mix)
                    FEW_BYTES: c = 8'(base + $urandom_range(3));
                    ANY_BYTE:  c = 8'($urandom_range(255));
                    default:   c = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : base;
                endcase
                send_byte(c, k == len - 1, 1'b0, '0);
                sent++;
            end
        end

        // Saturation: one byte runs past MAX_LEN among sparse noise; its
        // reported count holds at MAX_LEN.
        heavy = 8'($urandom_range(255));
        for (k = 0; k < MAX_LEN + 3; k++) begin
            if ($urandom_range(15) == 0)
                send_byte(8'($urandom_range(255)), 1'b0, 1'b0, '0);
            send_byte(heavy, k == MAX_LEN + 2, 1'b0, '0);
        end

        @(negedge aclk);
        s_valid = 1'b0;

        // Drain: the watchdog covers a result that never comes.
        while (pending_modes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_modes.size() != 0)
            report("result never delivered", pending_modes[0], '0);

        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
